>>> rtl/tle_pkg.sv
// Shared constants, codes and control/status types for the terminal line editor.
`timescale 1ns / 1ps

package tle_pkg;

   // Default line buffer depth
   localparam int LINE_DEPTH_DEF = 32;

   // Character codes
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_BS    = 8'h08;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ESC   = 8'h1B;
   localparam logic [7:0] CHAR_LBRK  = 8'h5B;
   localparam logic [7:0] CHAR_K     = 8'h4B;

   // Destination codes
   localparam logic DEST_TERM = 1'b0;
   localparam logic DEST_LINE = 1'b1;

   // Source of the next result beat
   typedef enum logic [2:0] {
      OSEL_ECHO = 3'd0,
      OSEL_ESC  = 3'd1,
      OSEL_LBRK = 3'd2,
      OSEL_K    = 3'd3,
      OSEL_LINE = 3'd4,
      OSEL_TERM = 3'd5
   } osel_type;

   // Controller to datapath
   typedef struct packed {
      logic     load_item;
      logic     emit;
      osel_type osel;
      logic     last;
      logic     store;
      logic     pos_clr;
      logic     pos_dec;
      logic     idx_clr;
      logic     idx_inc;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;
      logic is_line_end;
      logic is_bs;
      logic is_print;
      logic pos_zero;
      logic idx_last;
   } status_type;

endpackage

>>> rtl/tle_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/tle_ctrl.sv
// Sequencer for the line editor: accepts a beat and steps through its results.
`timescale 1ns / 1ps

module tle_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tle_pkg::status_type status,
   output tle_pkg::cmd_type    cmd
);

   import tle_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_ECHO      = 8'b0000_0010,
      ST_ESC1      = 8'b0000_0100,
      ST_ESC2      = 8'b0000_1000,
      ST_ESC3      = 8'b0001_0000,
      ST_DUMP_ADDR = 8'b0010_0000,
      ST_DUMP_EMIT = 8'b0100_0000,
      ST_TERM      = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // Next state and command decode
   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.osel      = OSEL_ECHO;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_ECHO;
            end
         end
         ST_ECHO: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.osel = OSEL_ECHO;
               cmd.last = !(status.is_line_end || status.is_bs);
               if (status.is_line_end) begin
                  cmd.idx_clr = 1'b1;
                  state_in    = status.pos_zero ? ST_TERM : ST_DUMP_ADDR;
               end else if (status.is_bs) begin
                  cmd.pos_dec = 1'b1;
                  state_in    = ST_ESC1;
               end else begin
                  cmd.store = status.is_print;
                  state_in  = ST_IDLE;
               end
            end
         end
         ST_ESC1: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.osel = OSEL_ESC;
               state_in = ST_ESC2;
            end
         end
         ST_ESC2: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.osel = OSEL_LBRK;
               state_in = ST_ESC3;
            end
         end
         ST_ESC3: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.osel = OSEL_K;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         // RAM read address settles here; data is registered into the next state
         ST_DUMP_ADDR: begin
            state_in = ST_DUMP_EMIT;
         end
         ST_DUMP_EMIT: begin
            if (status.out_free) begin
               cmd.emit    = 1'b1;
               cmd.osel    = OSEL_LINE;
               cmd.idx_inc = 1'b1;
               state_in    = status.idx_last ? ST_TERM : ST_DUMP_ADDR;
            end
         end
         ST_TERM: begin
            if (status.out_free) begin
               cmd.emit    = 1'b1;
               cmd.osel    = OSEL_TERM;
               cmd.last    = 1'b1;
               cmd.pos_clr = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/tle_dp.sv
// Datapath: held input byte, write position, read index, line store and output register.
`timescale 1ns / 1ps

module tle_dp #(
   parameter int LINE_DEPTH = tle_pkg::LINE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_rx_byte,
   input  tle_pkg::cmd_type    cmd,
   output tle_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_dest,
   output logic                rsp_last_of_run
);

   import tle_pkg::*;

   localparam int PTR_W = $clog2(LINE_DEPTH);

   logic [7:0]       item_ff;
   logic [PTR_W-1:0] pos_ff, pos_in;
   logic [PTR_W-1:0] idx_ff, idx_in;
   logic [7:0]       rd_data;
   logic             rsp_valid_ff;
   logic [7:0]       out_byte_ff;
   logic             dest_ff;
   logic             last_ff;
   logic [7:0]       out_byte_in;

   // Input beat capture, carriage return folded into the terminator
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= (req_rx_byte == CHAR_CR) ? CHAR_GT : req_rx_byte;
      end
   end

   // Write position
   always_comb begin
      pos_in = pos_ff;
      if (cmd.pos_clr) begin
         pos_in = '0;
      end else if (cmd.pos_dec) begin
         if (pos_ff != '0) begin
            pos_in = pos_ff - PTR_W'(1);
         end
      end else if (cmd.store) begin
         pos_in = (pos_ff == PTR_W'(LINE_DEPTH - 1)) ? '0 : pos_ff + PTR_W'(1);
      end
   end

   // Line read index
   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         idx_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         idx_ff <= idx_in;
      end
   end

   // Line store
   tle_ram #(
      .WIDTH (8),
      .DEPTH (LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (pos_ff),
      .wr_data (item_ff),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // Result byte select
   always_comb begin
      case (cmd.osel)
         OSEL_ECHO: out_byte_in = item_ff;
         OSEL_ESC:  out_byte_in = CHAR_ESC;
         OSEL_LBRK: out_byte_in = CHAR_LBRK;
         OSEL_K:    out_byte_in = CHAR_K;
         OSEL_LINE: out_byte_in = rd_data;
         OSEL_TERM: out_byte_in = CHAR_GT;
         default:   out_byte_in = item_ff;
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_byte_ff <= out_byte_in;
         dest_ff     <= ((cmd.osel == OSEL_LINE) || (cmd.osel == OSEL_TERM)) ?
                        DEST_LINE : DEST_TERM;
         last_ff     <= cmd.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_dest        = dest_ff;
   assign rsp_last_of_run = last_ff;

   // Status back to the controller
   always_comb begin
      status.out_free    = !rsp_valid_ff || rsp_ready;
      status.is_line_end = (item_ff == CHAR_GT);
      status.is_bs       = (item_ff == CHAR_BS);
      status.is_print    = (item_ff >= CHAR_SPACE);
      status.pos_zero    = (pos_ff == '0);
      status.idx_last    = ({1'b0, idx_ff} + (PTR_W + 1)'(1)) == {1'b0, pos_ff};
   end

   // A new result never overwrites one still waiting
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending beat");

   // Write position stays inside the buffer
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, pos_ff} < (PTR_W + 1)'(LINE_DEPTH))
      else $error("write position out of range");

   // Line dump only reads entries below the write position
   a_dump_idx: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && (cmd.osel == OSEL_LINE)) |-> (idx_ff < pos_ff))
      else $error("line read beyond write position");

   // Terminator beat leaves the position at zero
   a_term_clr: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && (cmd.osel == OSEL_TERM)) |=> (pos_ff == '0))
      else $error("position not cleared after line end");

endmodule

>>> rtl/terminal_line_editor_core.sv
// The input byte is registered as the held item; its echo beat is then loaded into the output register once free.
// A plain byte gives one echo beat; a backspace gives four (echo plus ESC [ K, one beat each).
// Line end: echo, each stored byte via an address and an emit state for the RAM read, terminator.
// Output stalls hold the sequencer; a new input is taken while the final result beat still waits.
// Reset: write position zero, output register empty; line store contents are not cleared.
`timescale 1ns / 1ps

module terminal_line_editor_core #(
   parameter int LINE_DEPTH = tle_pkg::LINE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_dest,
   output logic       rsp_last_of_run
);

   import tle_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer
   tle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath
   tle_dp #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_rx_byte     (req_rx_byte),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_dest        (rsp_dest),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the terminal line editor core.
`timescale 1ns / 1ps

module tb;
   import tle_pkg::*;

   localparam int LINE_LEN     = LINE_DEPTH_DEF;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 80;
   localparam int RANDOM_ITEMS = 210;
   localparam int MAX_IDLE     = 17;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       dest;
      logic       last_of_run;
   } editor_beat_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_ready   = 1'b0;
   wire        req_ready;
   wire        rsp_valid;
   wire  [7:0] rsp_out_byte;
   wire        rsp_dest;
   wire        rsp_last_of_run;

   // Editor image: stored line and next write position
   logic [7:0]      line_image [LINE_LEN];
   int              line_fill = 0;
   editor_beat_type expected_beats [$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int bytes_typed    = 0;
   int random_goal    = 0;
   bit req_idle_on    = 1'b1;
   bit rsp_idle_on    = 1'b1;

   terminal_line_editor_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_dest        (rsp_dest),
      .rsp_last_of_run (rsp_last_of_run)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic void expect_beat(input logic [7:0] b, input logic d, input logic l);
      expected_beats.push_back(editor_beat_type'{out_byte: b, dest: d, last_of_run: l});
   endfunction

   // Work out the beats that one accepted byte produces
   function automatic void predict_line_edit(input logic [7:0] rx);
      logic [7:0] ch;
      ch = (rx == CHAR_CR) ? CHAR_GT : rx;
      if (ch == CHAR_GT) begin
         expect_beat(ch, DEST_TERM, 1'b0);
         for (int i = 0; i < line_fill; i++)
            expect_beat(line_image[i], DEST_LINE, 1'b0);
         expect_beat(CHAR_GT, DEST_LINE, 1'b1);
         line_fill = 0;
      end else if (ch == CHAR_BS) begin
         if (line_fill != 0)
            line_fill--;
         expect_beat(ch, DEST_TERM, 1'b0);
         expect_beat(CHAR_ESC, DEST_TERM, 1'b0);
         expect_beat(CHAR_LBRK, DEST_TERM, 1'b0);
         expect_beat(CHAR_K, DEST_TERM, 1'b1);
      end else begin
         expect_beat(ch, DEST_TERM, 1'b1);
         if (ch >= CHAR_SPACE) begin
            line_image[line_fill] = ch;
            line_fill = (line_fill + 1 >= LINE_LEN) ? 0 : line_fill + 1;
         end
      end
   endfunction

   // Compare one received beat with the oldest expectation
   function automatic void check_beat(input editor_beat_type seen);
      editor_beat_type want;
      if (expected_beats.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected beat: byte %h dest %b last %b",
                     seen.out_byte, seen.dest, seen.last_of_run);
      end else begin
         want = expected_beats.pop_front();
         if (seen !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("beat mismatch: exp byte %h dest %b last %b, got byte %h dest %b last %b",
                        want.out_byte, want.dest, want.last_of_run,
                        seen.out_byte, seen.dest, seen.last_of_run);
         end
      end
   endfunction

   // Present one byte; returns at the edge that accepts it, valid left high
   task automatic type_byte(input logic [7:0] b);
      int gap;
      gap = req_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      predict_line_edit(b);
      bytes_typed++;
   endtask

   function automatic logic [7:0] rand_printable();
      logic [7:0] b;
      do b = 8'($urandom_range(CHAR_SPACE, 8'hFF)); while (b == CHAR_GT);
      return b;
   endfunction

   function automatic logic [7:0] rand_control();
      logic [7:0] b;
      do b = 8'($urandom_range(0, CHAR_SPACE - 1)); while (b == CHAR_BS || b == CHAR_CR);
      return b;
   endfunction

   // Response side: random ready stalls, capture at negedge, check after the edge
   initial begin : result_monitor
      int stall;
      editor_beat_type seen;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(negedge clock); while (!rsp_valid);
         seen = '{out_byte: rsp_out_byte, dest: rsp_dest, last_of_run: rsp_last_of_run};
         @(posedge clock);
         check_beat(seen);
      end
   end

   // Printable extremes are stored, then a CR flushes them
   task automatic test_plain_echo();
      type_byte(CHAR_SPACE);
      type_byte(8'hFF);
      type_byte(8'h7F);
      type_byte(8'h41);
      type_byte(8'h80);
      type_byte(CHAR_CR);
   endtask

   // Other control bytes echo only; an empty line still ends with the terminator
   task automatic test_control_bytes();
      type_byte(8'h00);
      type_byte(8'h1F);
      type_byte(CHAR_ESC);
      type_byte(8'h0A);
      type_byte(CHAR_GT);
   endtask

   // Backspace at position zero, then erasing a stored byte
   task automatic test_backspace();
      type_byte(CHAR_BS);
      type_byte(8'h78);
      type_byte(8'h79);
      type_byte(CHAR_BS);
      type_byte(8'h7A);
      type_byte(CHAR_CR);
   endtask

   // Typed '>' ends a line like CR does
   task automatic test_line_terminators();
      type_byte(8'h71);
      type_byte(CHAR_GT);
      type_byte(CHAR_CR);
   endtask

   // Lines that fill and wrap the buffer, no idling on either side
   task automatic test_long_lines();
      int len;
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      for (int n = 0; n < 2; n++) begin
         len = (n == 0) ? LINE_LEN : $urandom_range(LINE_LEN + 1, LINE_LEN + 8);
         for (int i = 0; i < len; i++)
            type_byte(rand_printable());
         if (n == 1)
            type_byte(CHAR_BS);
         type_byte(CHAR_CR);
      end
   endtask

   // Mostly edited lines with random content, some raw noise
   task automatic test_random_lines();
      int kind;
      int len;
      int pick;
      while (bytes_typed < random_goal) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         kind = $urandom_range(0, 99);
         if (kind < 15) begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
               type_byte(8'($urandom_range(0, 255)));
         end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, LINE_LEN + 3)
                                              : $urandom_range(0, 10);
            for (int i = 0; i < len; i++) begin
               pick = $urandom_range(0, 99);
               if (pick < 10)
                  type_byte(CHAR_BS);
               else if (pick < 14)
                  type_byte(rand_control());
               else
                  type_byte(rand_printable());
            end
            type_byte(($urandom_range(0, 1) != 0) ? CHAR_CR : CHAR_GT);
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_plain_echo();
      test_control_bytes();
      test_backspace();
      test_line_terminators();
      // Total byte count for the whole run, directed bytes included
      random_goal = RANDOM_ITEMS;
      test_long_lines();
      test_random_lines();
      req_valid <= 1'b0;

      // Drain outstanding beats, then watch for strays
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_beats.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
